// ----- rtl/mdpp_pkg.sv -----
// Shared types, widths and codes for the min-distance point picker.
package mdpp_pkg;

    localparam int COORD_W    = 16;
    localparam int HALF_W     = 15;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = HALF_W + FRAC_W;
    localparam int CNT_W      = 9;
    localparam int TRY_W      = 17;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W - 2;
    localparam int SUM_W      = SQ_W + 1;
    localparam int LIM_W      = 2 * HALF_W;

    localparam logic [CNT_W-1:0] POINTS_WANTED_RST = CNT_W'(1);
    localparam logic [TRY_W-1:0] TRY_LIMIT_RST     = TRY_W'(100000);

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_CAND  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_REJECT = 3'd1;
    localparam logic [STATUS_W-1:0] STS_ACCEPT = 3'd2;
    localparam logic [STATUS_W-1:0] STS_GAVEUP = 3'd3;
    localparam logic [STATUS_W-1:0] STS_IGNORE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS_WANTED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [FRAC_W-1:0]         rand_x;
        logic [FRAC_W-1:0]         rand_y;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [IDX_W-1:0]          point_index;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic vld;
        logic excl;
        logic last;
    } t_scan_ctl;

    typedef struct packed {
        logic vld;
        logic bad;
        logic last;
    } t_scan_res;

endpackage

// ----- rtl/mdpp_store.sv -----
// Point store: one write port and one registered read port.
module mdpp_store #(
    parameter int DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  mdpp_pkg::t_point                i_wdata,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output mdpp_pkg::t_point                o_rdata
);
    import mdpp_pkg::*;

    t_point r_mem [DEPTH];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mdpp_dist.sv -----
// Pipelined squared-distance check of the candidate against one point (or the anchor) per cycle.
module mdpp_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mdpp_pkg::t_scan_ctl               i_ctl,
    input  mdpp_pkg::t_point                  i_pt,
    input  mdpp_pkg::t_point                  i_cand,
    input  mdpp_pkg::t_point                  i_anchor,
    input  logic [mdpp_pkg::HALF_W-1:0]       i_min_dist,
    input  logic [mdpp_pkg::HALF_W-1:0]       i_excl_radius,
    output mdpp_pkg::t_scan_res               o_res
);
    import mdpp_pkg::*;

    logic [LIM_W-1:0]         w_min_sq;
    logic [LIM_W-1:0]         w_excl_sq;
    logic [LIM_W-1:0]         r_min_sq;
    logic [LIM_W-1:0]         r_excl_sq;
    t_point                   w_sel;
    logic [DIFF_W-1:0]        w_dx;
    logic [DIFF_W-1:0]        w_dy;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [2*DIFF_W-1:0] w_sqx;
    logic signed [2*DIFF_W-1:0] w_sqy;
    logic [SQ_W-1:0]          r_sqx;
    logic [SQ_W-1:0]          r_sqy;
    logic [SUM_W-1:0]         w_sum;
    logic [LIM_W-1:0]         w_lim;
    logic                     w_below;
    t_scan_ctl                r_c1;
    t_scan_ctl                r_c2;
    t_scan_res                r_res;

    assign w_min_sq  = LIM_W'(i_min_dist) * LIM_W'(i_min_dist);
    assign w_excl_sq = LIM_W'(i_excl_radius) * LIM_W'(i_excl_radius);

    assign w_sel = i_ctl.excl ? i_anchor : i_pt;
    assign w_dx  = {i_cand.x[COORD_W-1], i_cand.x} - {w_sel.x[COORD_W-1], w_sel.x};
    assign w_dy  = {i_cand.y[COORD_W-1], i_cand.y} - {w_sel.y[COORD_W-1], w_sel.y};

    assign w_sqx = (2*DIFF_W)'(r_dx) * (2*DIFF_W)'(r_dx);
    assign w_sqy = (2*DIFF_W)'(r_dy) * (2*DIFF_W)'(r_dy);

    assign w_sum   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_lim   = r_c2.excl ? r_excl_sq : r_min_sq;
    assign w_below = w_sum < {{(SUM_W-LIM_W){1'b0}}, w_lim};

    always_ff @(posedge i_clk) begin
        r_min_sq  <= w_min_sq;
        r_excl_sq <= w_excl_sq;
        r_dx      <= w_dx;
        r_dy      <= w_dy;
        r_sqx     <= w_sqx[SQ_W-1:0];
        r_sqy     <= w_sqy[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1  <= '0;
            r_c2  <= '0;
            r_res <= '0;
        end else begin
            r_c1      <= i_ctl;
            r_c2      <= r_c1;
            r_res.vld <= r_c2.vld;
            r_res.bad <= r_c2.vld & w_below;
            r_res.last <= r_c2.vld & r_c2.last;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/min_distance_point_picker_core.sv -----
// Top level of the dart-throwing point picker: control, registers and result stage.
//
//  Channel   Signals                               Moves
//  input     i_in_valid / o_in_ready / i_in_data   one command beat (clear, load, candidate)
//  output    o_out_valid / i_out_ready / o_out_data one result beat per command
//  config    i_cfg_we / i_cfg_idx / i_cfg_data     register write, no handshake
//
// Clear, load and ignored beats give their result one cycle after acceptance.
// A candidate blocks new beats until its result is given, and the next beat can be taken
// once that result is out or being taken: the store is read one entry per cycle into the
// squared-distance pipeline, after one check against the anchor.
// Reset is synchronous and active low; the store itself is not cleared by reset.
// A stalled output holds the result and blocks new input beats until it is taken.
module min_distance_point_picker_core #(
    parameter int MAX_POINTS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  mdpp_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output mdpp_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [mdpp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mdpp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mdpp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [HALF_W-1:0]         r_min_dist;
    logic [HALF_W-1:0]         r_half_w;
    logic [HALF_W-1:0]         r_half_h;
    logic [HALF_W-1:0]         r_excl;
    logic signed [COORD_W-1:0] r_anchor_x;
    logic signed [COORD_W-1:0] r_anchor_y;
    logic [CNT_W-1:0]          r_pts_wanted;
    logic [TRY_W-1:0]          r_try_limit;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CW-1:0]    r_stored;
    logic [CW-1:0]    n_stored;
    logic [CNT_W-1:0] r_new;
    logic [CNT_W-1:0] n_new;
    logic [TRY_W-1:0] r_try;
    logic [TRY_W-1:0] n_try;
    logic [CW-1:0]    r_k;
    logic [CW-1:0]    n_k;
    logic             r_bad;
    logic             n_bad;
    logic             r_out_vld;
    logic             n_out_vld;
    t_out_item        r_out;
    t_out_item        n_out;
    t_scan_ctl        r_ctl;

    logic [PROD_W-1:0] r_prod_x;
    logic [PROD_W-1:0] r_prod_y;
    logic [DIFF_W-1:0] w_sx;
    logic [DIFF_W-1:0] w_sy;
    t_point            r_cand;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_full;
    logic             w_ign_cand;
    logic [TRY_W-1:0] w_try_inc;
    logic [CNT_W-1:0] w_new_inc;
    logic [CW-1:0]    w_k_m1;
    logic             w_we;
    t_point           w_wdata;
    t_point           w_rdata;
    t_point           w_anchor;
    t_scan_res        w_res;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_stored == CW'(MAX_POINTS));
    assign w_ign_cand = (r_new >= r_pts_wanted) || w_full;
    assign w_try_inc  = r_try + TRY_W'(1);
    assign w_new_inc  = r_new + CNT_W'(1);
    assign w_k_m1     = r_k - CW'(1);

    assign w_sx = {1'b0, r_prod_x[PROD_W-1:FRAC_W-1]} - {2'b00, r_half_w};
    assign w_sy = {1'b0, r_prod_y[PROD_W-1:FRAC_W-1]} - {2'b00, r_half_h};

    assign w_anchor.x = r_anchor_x;
    assign w_anchor.y = r_anchor_y;

    always_comb begin
        n_state   = r_state;
        n_stored  = r_stored;
        n_new     = r_new;
        n_try     = r_try;
        n_k       = r_k;
        n_bad     = r_bad || (w_res.vld && w_res.bad);
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        w_we      = 1'b0;
        w_wdata   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    unique case (i_in_data.op)
                        OP_CLEAR: begin
                            n_stored     = '0;
                            n_new        = '0;
                            n_try        = '0;
                            n_out.status = STS_DONE;
                        end
                        OP_LOAD: begin
                            if (w_full) begin
                                n_out.status = STS_IGNORE;
                            end else begin
                                w_we          = 1'b1;
                                w_wdata.x     = i_in_data.coord_x;
                                w_wdata.y     = i_in_data.coord_y;
                                n_stored      = r_stored + CW'(1);
                                n_out.status  = STS_DONE;
                                n_out.point_x = i_in_data.coord_x;
                                n_out.point_y = i_in_data.coord_y;
                            end
                        end
                        OP_CAND: begin
                            if (w_ign_cand) begin
                                n_out.status = STS_IGNORE;
                            end else begin
                                n_out_vld = 1'b0;
                                n_out     = r_out;
                                n_state   = S_SCALE;
                            end
                        end
                        default: begin
                            n_out.status = STS_IGNORE;
                        end
                    endcase
                end
            end
            S_SCALE: begin
                n_k     = '0;
                n_bad   = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_k == r_stored) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_DRAIN: begin
                if (w_res.vld && w_res.last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                    n_out.point_index = r_new[IDX_W-1:0];
                    if (!r_bad || (w_try_inc >= r_try_limit)) begin
                        w_we       = 1'b1;
                        n_stored   = r_stored + CW'(1);
                        n_new      = w_new_inc;
                        n_try      = '0;
                        n_out.last = (w_new_inc == r_pts_wanted);
                        if (!r_bad) begin
                            w_wdata       = r_cand;
                            n_out.status  = STS_ACCEPT;
                            n_out.point_x = r_cand.x;
                            n_out.point_y = r_cand.y;
                        end else begin
                            w_wdata       = '0;
                            n_out.status  = STS_GAVEUP;
                            n_out.point_x = '0;
                            n_out.point_y = '0;
                        end
                    end else begin
                        n_try         = w_try_inc;
                        n_out.status  = STS_REJECT;
                        n_out.point_x = r_cand.x;
                        n_out.point_y = r_cand.y;
                        n_out.last    = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist   <= '0;
            r_half_w     <= '0;
            r_half_h     <= '0;
            r_excl       <= '0;
            r_anchor_x   <= '0;
            r_anchor_y   <= '0;
            r_pts_wanted <= POINTS_WANTED_RST;
            r_try_limit  <= TRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_DIST:    r_min_dist   <= i_cfg_data[HALF_W-1:0];
                CFG_HALF_WIDTH:  r_half_w     <= i_cfg_data[HALF_W-1:0];
                CFG_HALF_HEIGHT: r_half_h     <= i_cfg_data[HALF_W-1:0];
                CFG_EXCL_RADIUS: r_excl       <= i_cfg_data[HALF_W-1:0];
                CFG_ANCHOR_X:    r_anchor_x   <= i_cfg_data[COORD_W-1:0];
                CFG_ANCHOR_Y:    r_anchor_y   <= i_cfg_data[COORD_W-1:0];
                CFG_PTS_WANTED:  r_pts_wanted <= i_cfg_data[CNT_W-1:0];
                CFG_TRY_LIMIT:   r_try_limit  <= i_cfg_data[TRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stored  <= '0;
            r_new     <= '0;
            r_try     <= '0;
            r_k       <= '0;
            r_bad     <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctl     <= '0;
        end else begin
            r_state   <= n_state;
            r_stored  <= n_stored;
            r_new     <= n_new;
            r_try     <= n_try;
            r_k       <= n_k;
            r_bad     <= n_bad;
            r_out_vld <= n_out_vld;
            r_ctl.vld  <= (r_state == S_SCAN);
            r_ctl.excl <= (r_k == '0);
            r_ctl.last <= (r_k == r_stored);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_in_acc) begin
            r_prod_x <= PROD_W'(r_half_w) * PROD_W'(i_in_data.rand_x);
            r_prod_y <= PROD_W'(r_half_h) * PROD_W'(i_in_data.rand_y);
        end
        if (r_state == S_SCALE) begin
            r_cand.x <= w_sx[COORD_W-1:0];
            r_cand.y <= w_sy[COORD_W-1:0];
        end
    end

    mdpp_store #(
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_stored[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_k_m1[AW-1:0]),
        .o_rdata (w_rdata)
    );

    mdpp_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (r_ctl),
        .i_pt          (w_rdata),
        .i_cand        (r_cand),
        .i_anchor      (w_anchor),
        .i_min_dist    (r_min_dist),
        .i_excl_radius (r_excl),
        .o_res         (w_res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    ap_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(MAX_POINTS))
        else $error("Stored point count exceeds the store depth.");

    ap_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_full)
        else $error("Store written while full.");

    ap_res_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.vld |-> (r_state == S_SCAN) || (r_state == S_DRAIN))
        else $error("Distance result arrived outside a scan.");

    ap_finish_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && ($past(r_state) != S_FINISH) |->
            $past(r_state) == S_DRAIN)
        else $error("Finish entered without draining the distance pipeline.");

endmodule

// ----- dv/min_distance_point_picker_core_tb.sv -----
// Self-checking testbench for the dart-throwing point picker core.
module min_distance_point_picker_core_tb;
    import mdpp_pkg::*;

    localparam int MAX_PTS = 256;
    localparam int END_WAIT = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [HALF_W-1:0]         min_dist;
        logic [HALF_W-1:0]         half_width;
        logic [HALF_W-1:0]         half_height;
        logic [HALF_W-1:0]         excl_radius;
        logic signed [COORD_W-1:0] anchor_x;
        logic signed [COORD_W-1:0] anchor_y;
        logic [CNT_W-1:0]          pts_wanted;
        logic [TRY_W-1:0]          try_limit;
    } t_picker_regs;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_picker_regs              pick_cfg;
    logic signed [COORD_W-1:0] store_x [MAX_PTS];
    logic signed [COORD_W-1:0] store_y [MAX_PTS];
    int unsigned               stored_n = 0;
    logic [CNT_W-1:0]          picked_n = '0;
    logic [TRY_W-1:0]          reject_run = '0;
    t_out_item                 pending_picks[$];
    int unsigned               live_beats = 0;
    int unsigned               mismatch_count = 0;
    int                        hold_cycles = 0;
    bit                        tx_gaps_on = 1'b1;
    bit                        rx_stalls_on = 1'b1;

    min_distance_point_picker_core #(.MAX_POINTS(MAX_PTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [HALF_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return HALF_W'($urandom_range(0, 32767));
            default: return HALF_W'($urandom_range(16'h0200, 16'h2000));
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_anchor();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_beat(input logic [OP_W-1:0] op);
        t_in_item b;
        b.op      = op;
        b.coord_x = COORD_W'($urandom);
        b.coord_y = COORD_W'($urandom);
        b.rand_x  = FRAC_W'($urandom);
        b.rand_y  = FRAC_W'($urandom);
        return b;
    endfunction

    function automatic t_in_item load_beat(input logic [15:0] x, input logic [15:0] y);
        t_in_item b;
        b = random_beat(OP_LOAD);
        b.coord_x = x;
        b.coord_y = y;
        return b;
    endfunction

    function automatic t_in_item cand_beat(input logic [15:0] rx, input logic [15:0] ry);
        t_in_item b;
        b = random_beat(OP_CAND);
        b.rand_x = rx;
        b.rand_y = ry;
        return b;
    endfunction

    function automatic longint scaled(input longint half, input longint frac);
        return ((half * frac) >>> 15) - half;
    endfunction

    function automatic longint sq_dist(input longint ax, input longint ay,
                                       input longint bx, input longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic t_out_item place_point(input logic [STATUS_W-1:0] st,
                                              input longint px, input longint py);
        t_out_item res;
        res.status      = st;
        res.point_x     = COORD_W'(px);
        res.point_y     = COORD_W'(py);
        res.point_index = picked_n[IDX_W-1:0];
        store_x[stored_n] = COORD_W'(px);
        store_y[stored_n] = COORD_W'(py);
        stored_n++;
        picked_n   = picked_n + 1'b1;
        reject_run = '0;
        res.last   = (picked_n == pick_cfg.pts_wanted);
        return res;
    endfunction

    function automatic t_out_item compute_pick_result(input t_in_item beat);
        t_out_item res;
        longint    cx;
        longint    cy;
        longint    excl_sq;
        longint    spacing_sq;
        bit        bad;
        res = '0;
        res.status = STS_IGNORE;
        case (beat.op)
            OP_CLEAR: begin
                stored_n   = 0;
                picked_n   = '0;
                reject_run = '0;
                res.status = STS_DONE;
            end
            OP_LOAD: begin
                if (stored_n < MAX_PTS) begin
                    store_x[stored_n] = beat.coord_x;
                    store_y[stored_n] = beat.coord_y;
                    stored_n++;
                    res.status  = STS_DONE;
                    res.point_x = beat.coord_x;
                    res.point_y = beat.coord_y;
                end
            end
            OP_CAND: begin
                if (picked_n < pick_cfg.pts_wanted && stored_n < MAX_PTS) begin
                    cx = scaled(longint'(pick_cfg.half_width), longint'(beat.rand_x));
                    cy = scaled(longint'(pick_cfg.half_height), longint'(beat.rand_y));
                    excl_sq    = longint'(pick_cfg.excl_radius) *
                                 longint'(pick_cfg.excl_radius);
                    spacing_sq = longint'(pick_cfg.min_dist) * longint'(pick_cfg.min_dist);
                    bad = sq_dist(cx, cy, longint'(signed'(pick_cfg.anchor_x)),
                                  longint'(signed'(pick_cfg.anchor_y))) < excl_sq;
                    for (int k = 0; k < stored_n && !bad; k++) begin
                        if (sq_dist(cx, cy, longint'(store_x[k]), longint'(store_y[k]))
                                < spacing_sq) begin
                            bad = 1'b1;
                        end
                    end
                    if (!bad) begin
                        res = place_point(STS_ACCEPT, cx, cy);
                    end else begin
                        reject_run = reject_run + 1'b1;
                        if (reject_run >= pick_cfg.try_limit) begin
                            res = place_point(STS_GAVEUP, 0, 0);
                        end else begin
                            res.status      = STS_REJECT;
                            res.point_x     = COORD_W'(cx);
                            res.point_y     = COORD_W'(cy);
                            res.point_index = picked_n[IDX_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_beat(input t_in_item beat);
        t_out_item want;
        int        gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        want = compute_pick_result(beat);
        if (want.status != STS_IGNORE) begin
            live_beats++;
        end
        pending_picks.push_back(want);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_registers(input t_picker_regs regs);
        write_reg(CFG_MIN_DIST, CFG_DATA_W'(regs.min_dist));
        write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(regs.half_width));
        write_reg(CFG_HALF_HEIGHT, CFG_DATA_W'(regs.half_height));
        write_reg(CFG_EXCL_RADIUS, CFG_DATA_W'(regs.excl_radius));
        write_reg(CFG_ANCHOR_X, {1'b0, regs.anchor_x});
        write_reg(CFG_ANCHOR_Y, {1'b0, regs.anchor_y});
        write_reg(CFG_PTS_WANTED, CFG_DATA_W'(regs.pts_wanted));
        write_reg(CFG_TRY_LIMIT, CFG_DATA_W'(regs.try_limit));
        i_cfg_we <= 1'b0;
        pick_cfg = regs;
    endtask

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected st=%0d x=%0d y=%0d idx=%0d last=%0d,",
                     what, want.status, want.point_x, want.point_y, want.point_index,
                     want.last);
            $display("    got st=%0d x=%0d y=%0d idx=%0d last=%0d",
                     got.status, got.point_x, got.point_y, got.point_index, got.last);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_picks.size() == 0) begin
                note_mismatch("Unexpected result beat", '0, o_out_data);
            end else begin
                want = pending_picks.pop_front();
                if (o_out_data.status !== want.status ||
                        o_out_data.point_x !== want.point_x ||
                        o_out_data.point_y !== want.point_y ||
                        o_out_data.point_index !== want.point_index ||
                        o_out_data.last !== want.last) begin
                    note_mismatch("Result mismatch", want, o_out_data);
                end
            end
        end
    end

    initial begin : result_receiver
        int stall;
        int n;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                stall = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_stalls_on) begin
                    stall = pick_gap();
                end
            end
        end
    end

    task automatic test_reset_values();
        send_beat(cand_beat(16'h1234, 16'hEDCB));
        send_beat(random_beat(OP_CAND));
        send_beat(random_beat(OP_UNUSED));
        send_beat(random_beat(OP_CLEAR));
        send_beat(load_beat(16'h7FFF, 16'h8000));
        send_beat(random_beat(OP_CAND));
        drain_results();
    endtask

    task automatic test_corner_cases();
        t_picker_regs regs;
        regs = '{min_dist: 15'h0400, half_width: 15'h7FFF, half_height: 15'h7FFF,
                 excl_radius: 15'h0200, anchor_x: 16'sh0000, anchor_y: 16'sh0000,
                 pts_wanted: 9'd4, try_limit: 17'd3};
        load_registers(regs);
        send_beat(random_beat(OP_CLEAR));
        send_beat(load_beat(16'h7FFF, 16'h7FFF));
        send_beat(load_beat(16'h8000, 16'h8000));
        send_beat(cand_beat(16'h8000, 16'h8000));
        send_beat(cand_beat(16'hFFFF, 16'hFFFF));
        send_beat(cand_beat(16'h0000, 16'h0000));
        send_beat(cand_beat(16'h8000, 16'h8000));
        send_beat(cand_beat(16'hC000, 16'h4000));
        send_beat(cand_beat(16'hC000, 16'h4000));
        send_beat(cand_beat(16'h4000, 16'hC000));
        send_beat(cand_beat(16'h2000, 16'h2000));
        send_beat(cand_beat(16'h6000, 16'h6000));
        send_beat(random_beat(OP_UNUSED));
        drain_results();

        // The anchor lies exactly one radius away in y, which must not reject.
        regs = '{min_dist: 15'h7FFF, half_width: 15'h7FFF, half_height: 15'h0000,
                 excl_radius: 15'h7FFF, anchor_x: 16'sh0000, anchor_y: 16'sh7FFF,
                 pts_wanted: 9'd2, try_limit: 17'd0};
        load_registers(regs);
        send_beat(random_beat(OP_CLEAR));
        send_beat(cand_beat(16'h8000, 16'h8000));
        send_beat(cand_beat(16'h8000, 16'h8000));
        send_beat(random_beat(OP_CAND));
        drain_results();

        regs.pts_wanted = '0;
        load_registers(regs);
        send_beat(random_beat(OP_CLEAR));
        send_beat(random_beat(OP_CAND));
        drain_results();
    endtask

    task automatic test_store_full();
        t_picker_regs regs;
        regs = '{min_dist: 15'h0000, half_width: 15'h0100, half_height: 15'h0100,
                 excl_radius: 15'h0000, anchor_x: 16'sh0000, anchor_y: 16'sh0000,
                 pts_wanted: 9'd256, try_limit: TRY_LIMIT_RST};
        load_registers(regs);
        send_beat(random_beat(OP_CLEAR));
        repeat (MAX_PTS) send_beat(random_beat(OP_CAND));
        send_beat(random_beat(OP_CAND));
        send_beat(random_beat(OP_LOAD));
        send_beat(random_beat(OP_CLEAR));
        repeat (MAX_PTS) send_beat(random_beat(OP_LOAD));
        send_beat(random_beat(OP_LOAD));
        send_beat(random_beat(OP_CAND));
        drain_results();
    endtask

    task automatic test_output_hold();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_cycles  = 400;
        send_beat(random_beat(OP_CLEAR));
        repeat (15) send_beat(random_beat($urandom_range(0, 1) ? OP_LOAD : OP_CAND));
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        drain_results();
    endtask

    task automatic test_random_sets();
        t_picker_regs regs;
        int unsigned  start_n;
        int unsigned  n_loads;
        int unsigned  tries;
        int unsigned  cap;
        int           n_sets;
        start_n = live_beats;
        while (live_beats - start_n < 640) begin
            drain_results();
            regs.half_width  = pick_span();
            regs.half_height = pick_span();
            case ($urandom_range(0, 9))
                0: regs.min_dist = '0;
                1: regs.min_dist = '1;
                default: regs.min_dist = HALF_W'($urandom_range(16'h0010, 16'h0600));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: regs.excl_radius = '0;
                4: regs.excl_radius = '1;
                default: regs.excl_radius = HALF_W'($urandom_range(0, 16'h1000));
            endcase
            regs.anchor_x = pick_anchor();
            regs.anchor_y = pick_anchor();
            case ($urandom_range(0, 24))
                0: regs.pts_wanted = '0;
                1: regs.pts_wanted = CNT_W'($urandom_range(40, 120));
                default: regs.pts_wanted = CNT_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 19))
                0: regs.try_limit = '0;
                1: regs.try_limit = '1;
                2, 3: regs.try_limit = TRY_W'($urandom_range(9, 300));
                default: regs.try_limit = TRY_W'($urandom_range(1, 8));
            endcase
            if (regs.pts_wanted > 12) begin
                regs.min_dist = HALF_W'($urandom_range(0, 16'h0040));
            end
            load_registers(regs);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            n_sets = (regs.pts_wanted > 12) ? 1 : $urandom_range(2, 5);
            repeat (n_sets) begin
                if (stored_n > 200 || $urandom_range(0, 9) != 0) begin
                    send_beat(random_beat(OP_CLEAR));
                end
                case ($urandom_range(0, 49))
                    0, 1, 2, 3: n_loads = $urandom_range(31, 150);
                    5, 6, 7, 8, 9, 10, 11, 12, 13, 14: n_loads = $urandom_range(7, 30);
                    default: n_loads = $urandom_range(0, 6);
                endcase
                repeat (n_loads) send_beat(random_beat(OP_LOAD));
                cap = 2 * pick_cfg.pts_wanted + 10;
                tries = 0;
                while (picked_n < pick_cfg.pts_wanted && stored_n < MAX_PTS && tries < cap)
                        begin
                    case ($urandom_range(0, 19))
                        0: send_beat(random_beat(OP_UNUSED));
                        1: send_beat(random_beat(OP_LOAD));
                        default: begin
                            send_beat(random_beat(OP_CAND));
                            tries++;
                        end
                    endcase
                end
                repeat ($urandom_range(0, 2)) send_beat(random_beat(OP_CAND));
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        drain_results();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        pick_cfg = '{min_dist: '0, half_width: '0, half_height: '0, excl_radius: '0,
                     anchor_x: '0, anchor_y: '0, pts_wanted: POINTS_WANTED_RST,
                     try_limit: TRY_LIMIT_RST};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_corner_cases();
        test_store_full();
        test_output_hold();
        test_random_sets();

        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_picks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
